// File: rtl/rlud_pkg.sv
// Shared constants, codes and structs for the run-length UART byte decoder.
// Used by the interfaces, the divider, the bit walker and the top level.
package rlud_pkg;

    localparam int RUN_TIME_BITS = 15;
    localparam int BIT_TIME_W    = 15;
    localparam int FRAME_LEN_W   = 7;
    localparam int COUNT_W       = 8;
    localparam int BYTE_W        = 8;
    localparam int BYTE_IDX_W    = 6;
    localparam int BIT_CNT_W     = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int NUM_W         = RUN_TIME_BITS + 1;
    localparam int DIV_CMP_W     = ((NUM_W > BIT_TIME_W) ? NUM_W : BIT_TIME_W) + COUNT_W + 1;
    localparam int DIV_STEP_W    = 4;

    localparam logic [BIT_TIME_W-1:0]  BIT_TIME_RESET  = BIT_TIME_W'(104);
    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = FRAME_LEN_W'(32);
    localparam logic [FRAME_LEN_W-1:0] MAX_FRAME       = FRAME_LEN_W'(64);
    localparam logic [COUNT_W-1:0]     MAX_RUN_BITS    = COUNT_W'(255);

    // bit counter positions inside a frame: start is 0, data 1..8, stop 9
    localparam logic [BIT_CNT_W-1:0] DATA_FIRST = BIT_CNT_W'(1);
    localparam logic [BIT_CNT_W-1:0] DATA_LAST  = BIT_CNT_W'(8);
    localparam logic [BIT_CNT_W-1:0] STOP_BIT   = BIT_CNT_W'(9);

    localparam logic [DIV_STEP_W-1:0] DIV_SAT_STEP = DIV_STEP_W'(COUNT_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_TIME  = 1'b0,
        CFG_FRAME_LEN = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                  valid;
        logic [BYTE_W-1:0]     value;
        logic [BYTE_IDX_W-1:0] index;
        logic                  last;
    } t_emit;

    typedef struct packed {
        logic busy;
        logic frame_done;
    } t_walk_stat;

    typedef struct packed {
        logic               clear;
        logic               load;
        logic               level;
        logic [COUNT_W-1:0] count;
    } t_walk_ctl;

endpackage

// File: rtl/rlud_if.sv
// Channel interfaces of the run-length UART byte decoder: symbol input,
// byte output and register write. Depends on rlud_pkg.
interface rlud_in_if;
    logic                                valid;
    logic                                ready;
    logic                                start_capture;
    logic                                level_a;
    logic [rlud_pkg::RUN_TIME_BITS-1:0]  time_a;
    logic                                level_b;
    logic [rlud_pkg::RUN_TIME_BITS-1:0]  time_b;

    modport source (output valid, start_capture, level_a, time_a, level_b, time_b,
                    input ready);
    modport sink   (input valid, start_capture, level_a, time_a, level_b, time_b,
                    output ready);
endinterface

interface rlud_out_if;
    logic                              valid;
    logic                              ready;
    logic [rlud_pkg::BYTE_W-1:0]       byte_value;
    logic [rlud_pkg::BYTE_IDX_W-1:0]   byte_index;
    logic                              frame_last;

    modport source (output valid, byte_value, byte_index, frame_last, input ready);
    modport sink   (input valid, byte_value, byte_index, frame_last, output ready);
endinterface

interface rlud_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rlud_pkg::CFG_IDX_W-1:0]   index;
    logic [rlud_pkg::BIT_TIME_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/rlud_div.sv
// Iterative rounding divider: run duration to whole bit times, saturated at 255.
// One restoring step per cycle. Depends on rlud_pkg.
module rlud_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [rlud_pkg::RUN_TIME_BITS-1:0]  i_time,
    input  logic [rlud_pkg::BIT_TIME_W-1:0]     i_bit_time,
    output logic                                o_done,
    output logic [rlud_pkg::COUNT_W-1:0]        o_bits
);

    logic                                 r_busy;
    logic                                 r_done;
    logic [rlud_pkg::DIV_STEP_W-1:0]      r_step;
    logic [rlud_pkg::NUM_W-1:0]           r_rem;
    logic [rlud_pkg::BIT_TIME_W-1:0]      r_den;
    logic [rlud_pkg::COUNT_W-1:0]         r_quo;

    logic [rlud_pkg::BIT_TIME_W-1:0]      bt;
    logic [rlud_pkg::NUM_W-1:0]           num;
    logic [rlud_pkg::DIV_CMP_W-1:0]       trial;
    logic [rlud_pkg::DIV_CMP_W-1:0]       diff;
    logic                                 ge;

    // zero bit time counts as one microsecond
    assign bt    = (i_bit_time == '0) ? rlud_pkg::BIT_TIME_W'(1) : i_bit_time;
    assign num   = rlud_pkg::NUM_W'(i_time) + rlud_pkg::NUM_W'(bt >> 1);
    assign trial = rlud_pkg::DIV_CMP_W'(r_den) << r_step;
    assign ge    = rlud_pkg::DIV_CMP_W'(r_rem) >= trial;
    assign diff  = rlud_pkg::DIV_CMP_W'(r_rem) - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= rlud_pkg::DIV_SAT_STEP;
            end else if (r_busy) begin
                if ((r_step == rlud_pkg::DIV_SAT_STEP && ge) || r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - rlud_pkg::DIV_STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= num;
            r_den <= bt;
            r_quo <= '0;
        end else if (r_busy) begin
            if (r_step == rlud_pkg::DIV_SAT_STEP) begin
                // quotient would not fit in eight bits: saturate
                if (ge) begin
                    r_quo <= rlud_pkg::MAX_RUN_BITS;
                end
            end else begin
                if (ge) begin
                    r_rem <= diff[rlud_pkg::NUM_W-1:0];
                end
                r_quo[r_step[2:0]] <= ge;
            end
        end
    end

    assign o_done = r_done;
    assign o_bits = r_quo;

endmodule

// File: rtl/rlud_walk.sv
// 8N1 bit walker: consumes a run of equal bits in chunks and emits bytes.
// Holds the decoder state and the frame byte count. Depends on rlud_pkg.
module rlud_walk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rlud_pkg::t_walk_ctl                 i_ctl,
    input  logic [rlud_pkg::FRAME_LEN_W-1:0]    i_frame_length,
    input  logic                                i_out_free,
    output rlud_pkg::t_walk_stat                o_stat,
    output rlud_pkg::t_emit                     o_emit
);

    logic                                r_in_byte, n_in_byte;
    logic [rlud_pkg::BIT_CNT_W-1:0]      r_bit_cnt, n_bit_cnt;
    logic [rlud_pkg::BYTE_W-1:0]         r_shift, n_shift;
    logic [rlud_pkg::FRAME_LEN_W-1:0]    r_bytes, n_bytes;
    logic                                r_done, n_done;
    logic                                r_level, n_level;
    logic [rlud_pkg::COUNT_W-1:0]        r_cnt, n_cnt;

    logic                                active;
    logic [rlud_pkg::FRAME_LEN_W-1:0]    limit;
    logic [rlud_pkg::FRAME_LEN_W-1:0]    bytes_nx;
    logic [rlud_pkg::BIT_CNT_W-1:0]      remain;
    logic [rlud_pkg::BIT_CNT_W-1:0]      chunk;
    logic [rlud_pkg::BYTE_W:0]           ones;
    logic [2*rlud_pkg::BYTE_W-1:0]       mask;

    assign active   = (r_cnt != '0) && !r_done;
    assign bytes_nx = r_bytes + rlud_pkg::FRAME_LEN_W'(1);
    assign limit    = (i_frame_length == '0) ? rlud_pkg::FRAME_LEN_W'(1) :
                      (i_frame_length > rlud_pkg::MAX_FRAME) ? rlud_pkg::MAX_FRAME :
                      i_frame_length;

    // data bits still open in this frame, and how many of them this run covers
    assign remain = rlud_pkg::STOP_BIT - r_bit_cnt;
    assign chunk  = (r_cnt < {{(rlud_pkg::COUNT_W-rlud_pkg::BIT_CNT_W){1'b0}}, remain}) ?
                    r_cnt[rlud_pkg::BIT_CNT_W-1:0] : remain;
    assign ones   = ((rlud_pkg::BYTE_W+1)'(1) << chunk) - (rlud_pkg::BYTE_W+1)'(1);
    assign mask   = (2*rlud_pkg::BYTE_W)'(ones) << (r_bit_cnt - rlud_pkg::DATA_FIRST);

    always_comb begin
        n_in_byte    = r_in_byte;
        n_bit_cnt    = r_bit_cnt;
        n_shift      = r_shift;
        n_bytes      = r_bytes;
        n_done       = r_done;
        n_level      = r_level;
        n_cnt        = r_cnt;
        o_emit.valid = 1'b0;
        o_emit.value = r_shift;
        o_emit.index = r_bytes[rlud_pkg::BYTE_IDX_W-1:0];
        o_emit.last  = 1'b0;

        if (i_ctl.clear) begin
            n_in_byte = 1'b0;
            n_bit_cnt = '0;
            n_shift   = '0;
            n_bytes   = '0;
            n_done    = 1'b0;
            n_cnt     = '0;
        end else if (i_ctl.load) begin
            n_level = i_ctl.level;
            n_cnt   = i_ctl.count;
        end else if (active) begin
            if (!r_in_byte) begin
                if (!r_level) begin
                    n_in_byte = 1'b1;
                    n_bit_cnt = rlud_pkg::DATA_FIRST;
                    n_shift   = '0;
                    n_cnt     = r_cnt - rlud_pkg::COUNT_W'(1);
                end else begin
                    // skip idle high
                    n_cnt = '0;
                end
            end else begin
                case (r_bit_cnt) inside
                    [rlud_pkg::DATA_FIRST:rlud_pkg::DATA_LAST]: begin
                        if (r_level) begin
                            n_shift = r_shift | mask[rlud_pkg::BYTE_W-1:0];
                        end
                        n_bit_cnt = r_bit_cnt + chunk;
                        n_cnt     = r_cnt - rlud_pkg::COUNT_W'(chunk);
                    end
                    rlud_pkg::STOP_BIT: begin
                        if (r_level) begin
                            // hold until the output register can take the byte
                            if (i_out_free) begin
                                o_emit.valid = 1'b1;
                                o_emit.last  = (bytes_nx >= limit);
                                n_bytes      = bytes_nx;
                                n_done       = (bytes_nx >= limit);
                                n_in_byte    = 1'b0;
                                n_bit_cnt    = '0;
                                n_shift      = '0;
                                n_cnt        = r_cnt - rlud_pkg::COUNT_W'(1);
                            end
                        end else begin
                            // framing error: drop the byte
                            n_in_byte = 1'b0;
                            n_bit_cnt = '0;
                            n_shift   = '0;
                            n_cnt     = r_cnt - rlud_pkg::COUNT_W'(1);
                        end
                    end
                    default: begin
                        n_in_byte = 1'b0;
                        n_bit_cnt = '0;
                        n_shift   = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_byte <= 1'b0;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            r_bytes   <= '0;
            r_done    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_in_byte <= n_in_byte;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_bytes   <= n_bytes;
            r_done    <= n_done;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_level <= n_level;
    end

    assign o_stat.busy       = active;
    assign o_stat.frame_done = r_done;

endmodule

// File: rtl/run_length_uart_byte_decoder.sv
// Top level of the run-length UART byte decoder: sequencer, registers, output stage.
// Depends on rlud_pkg, rlud_if, rlud_div and rlud_walk.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+---------------------------------------------
//  i_in     | in  | valid / ready  | start_capture, level_a, time_a, level_b, time_b
//  o_out    | out | valid / ready  | byte_value, byte_index, frame_last
//  i_cfg    | in  | valid / ready  | index (0 bit_time_us, 1 frame_length), data
//
// One symbol at a time: the divider turns a run into whole bit times, one restoring
// step a cycle, and stops early when the count saturates at 255. The walker then takes
// one chunk per cycle (idle-high run, start bit, data bits, stop bit) unless a stop bit
// waits for the output register, then hands back to the sequencer. i_in.ready is high
// only between symbols.
// A byte that finds the output register full stalls the walker until o_out drains.
// Reset is synchronous; i_cfg is always ready.
module run_length_uart_byte_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rlud_in_if.sink      i_in,
    rlud_out_if.source   o_out,
    rlud_cfg_if.sink     i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIV_A  = 5'b00010,
        S_WALK_A = 5'b00100,
        S_DIV_B  = 5'b01000,
        S_WALK_B = 5'b10000
    } t_state;

    t_state                                r_state, n_state;
    logic [rlud_pkg::BIT_TIME_W-1:0]       r_bit_time;
    logic [rlud_pkg::FRAME_LEN_W-1:0]      r_frame_len;
    logic                                  r_level_a;
    logic                                  r_level_b;
    logic [rlud_pkg::RUN_TIME_BITS-1:0]    r_time_b;
    logic                                  r_out_valid;
    logic [rlud_pkg::BYTE_W-1:0]           r_out_value;
    logic [rlud_pkg::BYTE_IDX_W-1:0]       r_out_index;
    logic                                  r_out_last;

    logic                                  in_accept;
    logic                                  div_start;
    logic [rlud_pkg::RUN_TIME_BITS-1:0]    div_time;
    logic                                  div_done;
    logic [rlud_pkg::COUNT_W-1:0]          div_bits;
    logic                                  out_free;
    rlud_pkg::t_walk_ctl                   w_ctl;
    rlud_pkg::t_walk_stat                  w_stat;
    rlud_pkg::t_emit                       w_emit;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_accept   = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    assign div_start = in_accept || (r_state == S_WALK_A && !w_stat.busy);
    assign div_time  = (r_state == S_IDLE) ? i_in.time_a : r_time_b;

    assign w_ctl.clear = in_accept && i_in.start_capture;
    assign w_ctl.load  = div_done && (r_state == S_DIV_A || r_state == S_DIV_B);
    assign w_ctl.level = (r_state == S_DIV_A) ? r_level_a : r_level_b;
    assign w_ctl.count = div_bits;

    rlud_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_time     (div_time),
        .i_bit_time (r_bit_time),
        .o_done     (div_done),
        .o_bits     (div_bits)
    );

    rlud_walk u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_frame_length (r_frame_len),
        .i_out_free     (out_free),
        .o_stat         (w_stat),
        .o_emit         (w_emit)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_accept)      n_state = S_DIV_A;
            S_DIV_A:  if (div_done)       n_state = S_WALK_A;
            S_WALK_A: if (!w_stat.busy)   n_state = S_DIV_B;
            S_DIV_B:  if (div_done)       n_state = S_WALK_B;
            S_WALK_B: if (!w_stat.busy)   n_state = S_IDLE;
            default:                      n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit_time  <= rlud_pkg::BIT_TIME_RESET;
            r_frame_len <= rlud_pkg::FRAME_LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    rlud_pkg::CFG_BIT_TIME:  r_bit_time  <= i_cfg.data;
                    rlud_pkg::CFG_FRAME_LEN: r_frame_len <= i_cfg.data[rlud_pkg::FRAME_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (w_emit.valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_level_a <= i_in.level_a;
            r_level_b <= i_in.level_b;
            r_time_b  <= i_in.time_b;
        end
        if (w_emit.valid) begin
            r_out_value <= w_emit.value;
            r_out_index <= w_emit.index;
            r_out_last  <= w_emit.last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.byte_value = r_out_value;
    assign o_out.byte_index = r_out_index;
    assign o_out.frame_last = r_out_last;

`ifndef ASSERT_OFF
    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit.valid |-> out_free)
        else $error("byte emitted while output register is held");

    a_no_emit_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.frame_done |-> !w_emit.valid)
        else $error("byte emitted after frame completed");

    a_idle_walker_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_stat.busy)
        else $error("walker still busy between symbols");
`endif

endmodule
